[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define DRS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DRS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/drs_pkg.sv]
// Shared types and constants for the decimal radix sorter.
`default_nettype none
package drs_pkg;

  // Store geometry and key width
  localparam int DEPTH  = 64;
  localparam int ADDR_W = 6;
  localparam int CNT_W  = 7;
  localparam int KEY_W  = 32;
  localparam int RADIX  = 10;

  // Reciprocal of ten for 32-bit quotients: q / 10 = (q * RECIP10) >> RECIP_SHIFT
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Powers of ten that bound each decimal digit count
  localparam logic [31:0] POW10 [RADIX] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  // Word passed from the front to the back through the queue
  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic             last;
    logic             keep;
  } drs_word_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_OFS_RD,
    ST_OFS_WR,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_MUL,
    ST_CNT_DIG,
    ST_PFX,
    ST_SCT_RD,
    ST_SCT_MUL,
    ST_SCT_DIG,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } drs_state_t;

  // Number of decimal digits of a range (zero for a zero range)
  function automatic logic [3:0] drs_digits(input logic [31:0] range);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < RADIX; k++) begin
      if (range >= POW10[k]) n = n + 4'd1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[src/drs_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module drs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/drs_queue.sv]
// Two-entry queue between the front and the back.
`default_nettype none
module drs_queue import drs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire drs_word_t push_word,
  output logic           full,
  input  wire logic      pop,
  output drs_word_t      pop_word,
  output logic           empty
);

  drs_word_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_word = slot[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_word;
  end

endmodule
`default_nettype wire

[src/drs_front.sv]
// Input side: accepts words and marks those that fit in the store.
`default_nettype none
module drs_front import drs_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [KEY_W-1:0] value,
  input  wire logic             last_in,
  output logic                  push,
  output drs_word_t             push_word,
  input  wire logic             full
);

  logic [CNT_W-1:0] count;

  assign in_stall        = full;
  assign push            = in_valid && !full;
  assign push_word.value = value;
  assign push_word.last  = last_in;
  assign push_word.keep  = (count < CNT_W'(MAX_ITEMS));

  // Per-set count of kept words
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (last_in)             count <= '0;
      else if (push_word.keep) count <= count + 1'b1;
    end
  end

endmodule
`default_nettype wire

[src/drs_back.sv]
// Sorting side: loads the store, runs the digit passes and emits the set.
`default_nettype none
module drs_back import drs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             descending,
  input  wire logic             q_empty,
  input  wire drs_word_t        q_word,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [KEY_W-1:0]      sorted_value,
  output logic                  last_out,
  output logic                  overflowed
);

  drs_state_t state, state_next;

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  idx;
  logic [KEY_W-1:0]  run_min;
  logic [KEY_W-1:0]  run_max;
  logic              drop;
  logic              sel;
  logic [3:0]        passes;
  logic [CNT_W-1:0]  counts [RADIX];
  logic [CNT_W-1:0]  acc;
  logic [3:0]        pfx_idx;
  logic [KEY_W-1:0]  hold_key;
  logic [KEY_W-1:0]  hold_q;
  logic [KEY_W-1:0]  quot;

  // RAM ports
  logic                wr_en, wr_dst, out_load;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [2*KEY_W-1:0]  wdata, a_rdata, b_rdata, src_rdata;
  logic                a_we, b_we;

  // Derived values
  logic [KEY_W-1:0]    src_key, src_q, ofs;
  logic [2*KEY_W-1:0]  prod;
  logic [KEY_W-1:0]    rem;
  logic [3:0]          digit;
  logic [CNT_W-1:0]    pos;
  logic                idx_end;
  logic [CNT_W-1:0]    emit_idx;
  logic [3:0]          range_passes;

  assign src_rdata    = sel ? b_rdata : a_rdata;
  assign src_key      = src_rdata[2*KEY_W-1:KEY_W];
  assign src_q        = src_rdata[KEY_W-1:0];
  assign ofs          = src_key - run_min;
  assign prod         = src_q * {{KEY_W{1'b0}}, RECIP10};
  assign rem          = hold_q - ((quot << 3) + (quot << 1));
  assign digit        = rem[3:0];
  assign pos          = counts[digit] - 1'b1;
  assign idx_end      = (idx == n - 1'b1);
  assign emit_idx     = descending ? (n - 1'b1 - idx) : idx;
  assign range_passes = drs_digits(run_max - run_min);

  // Target RAM of a write: source side unless writing the scatter copy
  assign a_we = wr_en && !(sel ^ wr_dst);
  assign b_we = wr_en &&  (sel ^ wr_dst);

  drs_ram #(.WIDTH(2*KEY_W), .DEPTH(DEPTH)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(a_rdata)
  );

  drs_ram #(.WIDTH(2*KEY_W), .DEPTH(DEPTH)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(b_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  // Next state and RAM controls
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    wr_dst     = 1'b0;
    waddr      = idx[ADDR_W-1:0];
    wdata      = {ofs, ofs};
    raddr      = idx[ADDR_W-1:0];
    out_load   = 1'b0;
    case (state)
      ST_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          wr_en = q_word.keep;
          waddr = n[ADDR_W-1:0];
          wdata = {q_word.value, q_word.value};
          if (q_word.last) state_next = ST_OFS_RD;
        end
      end
      ST_OFS_RD: state_next = ST_OFS_WR;
      ST_OFS_WR: begin
        wr_en = 1'b1;
        if (!idx_end)               state_next = ST_OFS_RD;
        else if (range_passes == 0) state_next = ST_EMIT_RD;
        else                        state_next = ST_CLR;
      end
      ST_CLR:     state_next = ST_CNT_RD;
      ST_CNT_RD:  state_next = ST_CNT_MUL;
      ST_CNT_MUL: state_next = ST_CNT_DIG;
      ST_CNT_DIG: state_next = idx_end ? ST_PFX : ST_CNT_RD;
      ST_PFX:     if (pfx_idx == 4'(RADIX - 1)) state_next = ST_SCT_RD;
      ST_SCT_RD:  state_next = ST_SCT_MUL;
      ST_SCT_MUL: state_next = ST_SCT_DIG;
      ST_SCT_DIG: begin
        wr_en  = 1'b1;
        wr_dst = 1'b1;
        waddr  = pos[ADDR_W-1:0];
        wdata  = {hold_key, quot};
        if (idx == '0) state_next = (passes == 4'd1) ? ST_EMIT_RD : ST_CLR;
        else           state_next = ST_SCT_RD;
      end
      ST_EMIT_RD: begin
        raddr      = emit_idx[ADDR_W-1:0];
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        raddr = emit_idx[ADDR_W-1:0];
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = idx_end ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Set bookkeeping, passes and digit counts
  always_ff @(posedge clk) begin
    if (rst) begin
      n       <= '0;
      idx     <= '0;
      run_min <= '0;
      run_max <= '0;
      drop    <= 1'b0;
      sel     <= 1'b0;
      passes  <= '0;
      acc     <= '0;
      pfx_idx <= '0;
      for (int i = 0; i < RADIX; i++) counts[i] <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          idx <= '0;
          if (!q_empty) begin
            if (q_word.keep) begin
              if (n == '0) begin
                run_min <= q_word.value;
                run_max <= q_word.value;
              end else begin
                if ($signed(q_word.value) < $signed(run_min)) run_min <= q_word.value;
                if ($signed(q_word.value) > $signed(run_max)) run_max <= q_word.value;
              end
              n <= n + 1'b1;
            end else begin
              drop <= 1'b1;
            end
          end
        end
        ST_OFS_WR: begin
          passes <= range_passes;
          idx    <= idx_end ? '0 : idx + 1'b1;
        end
        ST_CLR: begin
          for (int i = 0; i < RADIX; i++) counts[i] <= '0;
          idx <= '0;
        end
        ST_CNT_DIG: begin
          counts[digit] <= counts[digit] + 1'b1;
          if (idx_end) begin
            idx     <= n - 1'b1;
            acc     <= '0;
            pfx_idx <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // Rotate the counts once around, turning them into running sums
        ST_PFX: begin
          for (int i = 0; i < RADIX - 1; i++) counts[i] <= counts[i+1];
          counts[RADIX-1] <= counts[0] + acc;
          acc             <= counts[0] + acc;
          pfx_idx         <= pfx_idx + 4'd1;
        end
        ST_SCT_DIG: begin
          counts[digit] <= pos;
          if (idx == '0) begin
            sel    <= ~sel;
            passes <= passes - 4'd1;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        ST_EMIT_WAIT: begin
          if (out_load) begin
            if (idx_end) begin
              idx     <= '0;
              n       <= '0;
              run_min <= '0;
              run_max <= '0;
              drop    <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Digit pipeline: quotient by ten, registered after the multiply
  always_ff @(posedge clk) begin
    if (state == ST_CNT_MUL || state == ST_SCT_MUL) begin
      hold_key <= src_key;
      hold_q   <= src_q;
      quot     <= KEY_W'(prod >> RECIP_SHIFT);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sorted_value <= src_key + run_min;
      last_out     <= idx_end;
      overflowed   <= drop;
    end
  end

endmodule
`default_nettype wire

[src/decimal_radix_sorter.sv]
// Top level of the decimal radix sorter.
// Collects a set of up to MAX_ITEMS signed 32-bit words (last_in closes the set), then emits
// them sorted, ascending or, with descending set, largest first, with last_out on the final
// word and overflowed on every word of a set that lost words to a full store. Keys are offset
// by the set minimum and sorted by stable base-ten passes, one per decimal digit of
// (max - min), zero to ten passes. Loading takes one word per cycle while the queue holds
// words; after the closing word the back end runs an offset sweep over the store, then per
// pass a counting and a scattering sweep (read, multiply-by-reciprocal, digit step through
// the store RAMs) with a prefix sum over the digit counts between them, and finally emits
// the words from the store. A two-word queue lets input words of the next set be taken
// while a set is still being sorted. No clearing pass is needed after reset.
`default_nettype none
module decimal_radix_sorter import drs_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [KEY_W-1:0] value,
  input  wire logic             last_in,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [KEY_W-1:0] sorted_value,
  output logic                  last_out,
  output logic                  overflowed,
  input  wire logic             cfg_write,
  input  wire logic             cfg_data
);

  logic      descending;
  logic      push, full, pop, empty;
  drs_word_t push_word, pop_word;

  // Order register
  always_ff @(posedge clk) begin
    if (rst)            descending <= 1'b0;
    else if (cfg_write) descending <= cfg_data;
  end

  drs_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .value(value), .last_in(last_in),
    .push(push), .push_word(push_word), .full(full)
  );

  drs_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_word(push_word), .full(full),
    .pop(pop), .pop_word(pop_word), .empty(empty)
  );

  drs_back u_back (
    .clk(clk), .rst(rst), .descending(descending),
    .q_empty(empty), .q_word(pop_word), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .sorted_value(sorted_value), .last_out(last_out), .overflowed(overflowed)
  );

endmodule
`default_nettype wire

[src/drs_checker.sv]
// Port-level checks for the decimal radix sorter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module drs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] sorted_value,
  input wire logic        last_out,
  input wire logic        overflowed
);

  // A stalled output word holds
  `DRS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(sorted_value) && $stable(last_out), "output word changed under stall")

  // Words of one set carry the same overflow mark
  `DRS_ASSERT(a_ovf_set, clk, rst, out_valid && !out_stall && !last_out |=> !out_valid || $stable(overflowed), "overflow mark changed within a set")

  // Reset leaves no output word pending
  `DRS_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind decimal_radix_sorter drs_checker u_drs_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .sorted_value(sorted_value), .last_out(last_out), .overflowed(overflowed)
);
`default_nettype wire

[tb/decimal_radix_sorter_tb.sv]
// Self-checking testbench for the decimal radix sorter: directed table, random sets, order check.
`timescale 1ns / 100ps
`default_nettype none
module decimal_radix_sorter_tb;
  import drs_pkg::*;

  localparam int MAX_ITEMS = 64;
  localparam int N_DIRECTED = 22;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KEY_W-1:0] value = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KEY_W-1:0] sorted_value;
  logic last_out;
  logic overflowed;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;

  // One sorted word as the block should emit it
  typedef struct {
    logic [31:0] val;
    logic        last;
    logic        ovf;
  } sorted_word_t;

  // One row of the directed table; chk_first types in the first expected value
  typedef struct {
    logic [31:0] val;
    logic        last;
    logic        chk_first;
    logic [31:0] first_val;
  } stim_row_t;

  sorted_word_t sorted_q[$];
  logic [31:0]  set_keys[$];
  logic         set_dropped;
  logic         desc_mode;
  logic [31:0]  typed_first[$];
  int           typed_set[$];
  logic [31:0]  firsts[$];
  logic         first_of_set = 1'b1;
  stim_row_t    dir_rows[N_DIRECTED];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int sets_done = 0;
  int cfg_writes = 0;

  decimal_radix_sorter #(.MAX_ITEMS(MAX_ITEMS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .value(value), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall), .sorted_value(sorted_value),
    .last_out(last_out), .overflowed(overflowed),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Radix sort of offset keys: stable LSD base-10 passes over the keys
  function automatic void radix_sort_offsets(ref logic [31:0] keys[$], input logic [31:0] range);
    logic [63:0] base;
    logic [31:0] scatter[$];
    int cnt[10];
    int d;
    base = 64'd1;
    while ((64'(range) / base) != 0) begin
      foreach (cnt[k]) cnt[k] = 0;
      foreach (keys[i]) cnt[int'((64'(keys[i]) / base) % 10)]++;
      for (int k = 1; k < 10; k++) cnt[k] += cnt[k-1];
      scatter = keys;
      for (int i = keys.size() - 1; i >= 0; i--) begin
        d = int'((64'(keys[i]) / base) % 10);
        cnt[d]--;
        scatter[cnt[d]] = keys[i];
      end
      keys = scatter;
      base = base * 10;
    end
  endfunction

  // Accept one input word into the predicted set; close the set on last
  task automatic predict_word(input logic [31:0] v, input logic lst);
    logic [31:0] mn, mx;
    int n;
    if (set_keys.size() < MAX_ITEMS) set_keys.push_back(v);
    else set_dropped = 1'b1;
    if (!lst) return;
    n = set_keys.size();
    mn = set_keys[0];
    mx = set_keys[0];
    foreach (set_keys[i]) begin
      if ($signed(set_keys[i]) < $signed(mn)) mn = set_keys[i];
      if ($signed(set_keys[i]) > $signed(mx)) mx = set_keys[i];
    end
    foreach (set_keys[i]) set_keys[i] = set_keys[i] - mn;
    radix_sort_offsets(set_keys, mx - mn);
    for (int i = 0; i < n; i++) begin
      sorted_word_t w;
      w.val  = set_keys[desc_mode ? n - 1 - i : i] + mn;
      w.last = (i == n - 1);
      w.ovf  = set_dropped;
      sorted_q.push_back(w);
    end
    set_keys.delete();
    set_dropped = 1'b0;
  endtask

  // Output checker with its own stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_out++;
        // first word of each set, for the typed table checks
        if (first_of_set) firsts.push_back(sorted_value);
        first_of_set = last_out;
        if (sorted_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected word %0d", $signed(sorted_value));
        end else begin
          sorted_word_t w;
          w = sorted_q.pop_front();
          if (w.last) sets_done++;
          if (sorted_value !== w.val || last_out !== w.last || overflowed !== w.ovf) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: word %0d exp val=%0d last=%0b ovf=%0b got val=%0d last=%0b ovf=%0b",
                       words_out, $signed(w.val), w.last, w.ovf, $signed(sorted_value),
                       last_out, overflowed);
          end
        end
      end
      // stall pattern: free stretches, sparse random and dense random stalls
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
      if ($urandom_range(0, 200) == 0) stall_mode = $urandom_range(0, 2);
    end
  end

  // Drive one input word, waiting for its acceptance
  task automatic send_word(input logic [31:0] v, input logic lst);
    in_valid <= 1'b1;
    value    <= v;
    last_in  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(v, lst);
    words_in++;
    // bursty sender: random gap after some words
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      value    <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic finish_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_desc(input logic d);
    cfg_write <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    desc_mode = d;
    cfg_writes++;
  endtask

  function automatic logic [31:0] rand_value(input int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 200)) - 100);
      2: return $urandom_range(0, 9);
      default: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                      ^ $urandom_range(0, 3);
    endcase
  endfunction

  initial begin
    int n, kind;
    int set_no;
    set_dropped = 1'b0;
    desc_mode = 1'b0;
    set_no = 0;
    // directed table: extremes, single word, duplicates, full-range span
    dir_rows = '{
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{32'd5,         1'b0, 1'b0, 32'h0},
      '{32'd5,         1'b0, 1'b0, 32'h0},
      '{32'd5,         1'b1, 1'b1, 32'd5},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'd1,         1'b0, 1'b0, 32'h0},
      '{32'd0,         1'b1, 1'b1, 32'hFFFF_FFFF},
      '{32'd123456789, 1'b0, 1'b0, 32'h0},
      '{32'd9,         1'b0, 1'b0, 32'h0},
      '{32'd1000,      1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FC18, 1'b0, 1'b0, 32'h0},
      '{32'd10,        1'b1, 1'b0, 32'h0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
      '{32'h5555_5555, 1'b1, 1'b0, 32'h0},
      '{32'd99,        1'b0, 1'b0, 32'h0},
      '{32'd100,       1'b0, 1'b0, 32'h0},
      '{32'd98,        1'b0, 1'b0, 32'h0},
      '{32'd101,       1'b1, 1'b0, 32'h0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_desc(1'b0);
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].val, dir_rows[i].last);
      if (dir_rows[i].last) begin
        if (dir_rows[i].chk_first) begin
          typed_set.push_back(set_no);
          typed_first.push_back(dir_rows[i].first_val);
        end
        set_no++;
      end
    end
    finish_idle();
    // typed expectation: first word of each closed set must match the table
    foreach (typed_set[j]) begin
      if (firsts.size() <= typed_set[j] || firsts[typed_set[j]] !== typed_first[j]) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: set %0d exp first=%0d got %0d", typed_set[j],
                   $signed(typed_first[j]),
                   (firsts.size() > typed_set[j]) ? $signed(firsts[typed_set[j]]) : 0);
      end
    end
    // overflow: 66 words into a 64 deep store, then full store with last
    write_desc(1'b1);
    for (int i = 0; i < 66; i++) send_word(rand_value(1), i == 65);
    for (int i = 0; i < 65; i++) send_word(rand_value(2), i == 64);
    finish_idle();
    // random sets, sometimes writing a random sort direction between sets
    while (words_in < 210) begin
      if ($urandom_range(0, 2) == 0) begin
        finish_idle();
        write_desc($urandom_range(0, 1));
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 12);
      kind = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) send_word(rand_value(kind), i == n - 1);
    end
    finish_idle();
    write_desc(1'b0);
    $display("Covered %0d input words, %0d sorted words, %0d sets, %0d direction writes",
             words_in, words_out, sets_done, cfg_writes);
    if (errors == 0 && sorted_q.size() == 0)
      $display("Testbench completed without errors");
    else begin
      $display("Mismatches: %0d, words still expected: %0d", errors, sorted_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("Timeout with %0d words still expected", sorted_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
